>>> rtl/hrb_pkg.sv
// shared constants, request codes, fsm states and control structs for the history ring buffer
// no dependencies

package hrb_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 64;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 64;
    localparam int OFF_W  = 7;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 6;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WALK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic push;
        logic clear;
        logic start_read;
        logic start_walk;
        logic emit;
    } hrb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic remain_one;
    } hrb_status_t;

endpackage

>>> rtl/history_ring_buffer.sv
// top level of the history ring buffer: request sequencer plus store datapath
// depends on hrb_pkg, hrb_ctrl and hrb_datapath
//
// usage:
//   s_ channel carries one request per transaction; s_tuser selects push, relative
//   read, walk or clear. push and clear produce nothing.
//   a relative read produces one m_ transaction, tlast set, tuser flagging an
//   offset at or beyond the depth in use (data and index then zero).
//   a walk produces one transaction per filled slot, newest first, tlast on the
//   oldest; an empty buffer gives slot zero once.
//   a read result passes from the registered read port of the entry store to the
//   output register; a walk streams one result per cycle after that while the
//   output register is free. s_tready stays low until the last result is in the
//   output register.
//   m_tready low holds the output register and pauses the walk.
//   cfg_wr_en loads depth_in_use (0 taken as 1, above the depth taken as the depth)
//   and empties the buffer, as does reset, which also sets the full depth.
//   the store is emptied at once through per-slot valid bits, with no sweep.

module history_ring_buffer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] data_in, [70:64] back_offset, [71] zero
    input  logic [hrb_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] data_out, [69:64] entry_index, [71:70] zero
    output logic [hrb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    // [0] offset_error
    output logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [hrb_pkg::CFG_W-1:0]       cfg_wr_data
);
    import hrb_pkg::*;

    hrb_cmd_t    cmd;
    hrb_status_t status;
    req_t        req;
    logic [DATA_W-1:0] data_out;
    logic [IDX_W-1:0]  entry_index;

    assign req = req_t'(s_tuser);

    hrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .req      (req),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hrb_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .data_in      (s_tdata[DATA_W-1:0]),
        .back_offset  (s_tdata[DATA_W+OFF_W-1:DATA_W]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .data_out     (data_out),
        .entry_index  (entry_index),
        .last_of_run  (m_tlast),
        .offset_error (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({entry_index, data_out});

`ifndef SYNTHESIS
    // an offset error result is a lone zero result
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("offset error result not zero or not last");

    // push and clear never leave the sequencer busy
    a_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (req == REQ_PUSH || req == REQ_CLEAR)) |=> s_tready)
        else $error("sequencer busy after push or clear");

    // a read or walk always holds off the next request
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (req == REQ_READ || req == REQ_WALK)) |=> !s_tready)
        else $error("request accepted while a run is starting");
`endif

endmodule

>>> rtl/hrb_ctrl.sv
// request sequencer of the history ring buffer
// depends on hrb_pkg for request codes, states and the command/status structs

module hrb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  hrb_pkg::req_t       req,
    output logic                s_tready,
    input  hrb_pkg::hrb_status_t status,
    output hrb_pkg::hrb_cmd_t   cmd
);
    import hrb_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (req == REQ_READ || req == REQ_WALK)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.remain_one) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (req)
                        REQ_PUSH:  cmd.push       = 1'b1;
                        REQ_READ:  cmd.start_read = 1'b1;
                        REQ_WALK:  cmd.start_walk = 1'b1;
                        REQ_CLEAR: cmd.clear      = 1'b1;
                        default:   cmd            = '0;
                    endcase
                end
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

>>> rtl/hrb_datapath.sv
// entry store, pointers, fill count and output register of the history ring buffer
// depends on hrb_pkg; driven by hrb_ctrl through the command struct

module hrb_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  hrb_pkg::hrb_cmd_t   cmd,
    output hrb_pkg::hrb_status_t status,
    input  logic                cfg_wr_en,
    input  logic [hrb_pkg::CFG_W-1:0]  cfg_wr_data,
    input  logic [hrb_pkg::DATA_W-1:0] data_in,
    input  logic [hrb_pkg::OFF_W-1:0]  back_offset,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [hrb_pkg::DATA_W-1:0] data_out,
    output logic [hrb_pkg::IDX_W-1:0]  entry_index,
    output logic                last_of_run,
    output logic                offset_error
);
    import hrb_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;

    logic [CNT_W-1:0] depth_reg;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             err_reg, err_next;

    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_hit_reg;
    logic [PTR_W-1:0]     rd_idx_reg;
    logic                 rd_en;
    logic [PTR_W-1:0]     rd_addr;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic                 out_last_reg;
    logic                 out_err_reg;

    logic             wipe;
    logic [CFG_W-1:0] cfg_depth;
    logic [CNT_W-1:0] wp_inc;
    logic             off_bad;
    logic [SUM_W-1:0] rel_sum;
    logic [SUM_W-1:0] rel_idx;
    logic [PTR_W-1:0] walk_start;
    logic [PTR_W-1:0] walk_nxt;

    function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] v,
                                                   input logic [CNT_W-1:0] fill);
        logic [PTR_W-1:0] r;
        if (v == '0) begin
            r = (fill == '0) ? '0 : PTR_W'(fill - CNT_W'(1));
        end else begin
            r = v - PTR_W'(1);
        end
        return r;
    endfunction

    assign wipe = cmd.clear || cfg_wr_en;

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_depth = CFG_W'(1);
        end else if (cfg_wr_data > CFG_W'(DEPTH)) begin
            cfg_depth = CFG_W'(DEPTH);
        end else begin
            cfg_depth = cfg_wr_data;
        end
    end

    // pointer and fill update on push
    assign wp_inc    = CNT_W'(wp_reg) + CNT_W'(1);
    assign wp_next   = (wp_inc == depth_reg) ? '0 : PTR_W'(wp_inc);
    assign fill_next = (fill_reg < depth_reg) ? fill_reg + CNT_W'(1) : fill_reg;

    // relative slot: (wp + depth - 1 - off) mod depth, one correction
    assign off_bad = back_offset >= OFF_W'(depth_reg);
    assign rel_sum = SUM_W'(wp_reg) + SUM_W'(depth_reg) - SUM_W'(1) - SUM_W'(back_offset);
    assign rel_idx = (rel_sum >= SUM_W'(depth_reg)) ? rel_sum - SUM_W'(depth_reg) : rel_sum;

    assign walk_start = step_back(wp_reg, fill_reg);
    assign walk_nxt   = step_back(cur_reg, fill_reg);

    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        cur_next    = cur_reg;
        remain_next = remain_reg;
        err_next    = err_reg;
        priority if (cmd.start_read) begin
            rd_en       = 1'b1;
            rd_addr     = PTR_W'(rel_idx);
            remain_next = CNT_W'(1);
            err_next    = off_bad;
        end else if (cmd.start_walk) begin
            rd_en       = 1'b1;
            rd_addr     = walk_start;
            cur_next    = walk_start;
            remain_next = (fill_reg == '0) ? CNT_W'(1) : fill_reg;
            err_next    = 1'b0;
        end else if (cmd.emit) begin
            remain_next = remain_reg - CNT_W'(1);
            if (remain_reg != CNT_W'(1)) begin
                rd_en    = 1'b1;
                rd_addr  = walk_nxt;
                cur_next = walk_nxt;
            end
        end else begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wp_reg] <= data_in[WORD_BITS-1:0];
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            depth_reg <= CNT_W'(DEPTH);
            wp_reg    <= '0;
            fill_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                depth_reg <= CNT_W'(cfg_depth);
            end
            if (wipe) begin
                valid_reg <= '0;
                wp_reg    <= '0;
                fill_reg  <= '0;
            end else if (cmd.push) begin
                valid_reg[wp_reg] <= 1'b1;
                wp_reg            <= wp_next;
                fill_reg          <= fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        remain_reg <= remain_next;
        err_reg    <= err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= (rd_hit_reg && !err_reg) ? DATA_W'(rd_data_reg) : '0;
            out_idx_reg  <= err_reg ? '0 : IDX_W'(rd_idx_reg);
            out_last_reg <= (remain_reg == CNT_W'(1));
            out_err_reg  <= err_reg;
        end
    end

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.remain_one = (remain_reg == CNT_W'(1));

    assign out_valid    = out_valid_reg;
    assign data_out     = out_data_reg;
    assign entry_index  = out_idx_reg;
    assign last_of_run  = out_last_reg;
    assign offset_error = out_err_reg;

endmodule
